FILE: rtl/core/lkt_pkg.sv
// Shared types and constants of the keyed entry table.
package lkt_pkg;

    localparam int FUNC_W = 2;
    localparam int CAP_W  = 5;
    localparam int SLOT_W = 4;
    localparam int EKEY_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_ACCESS = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PROBE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_rd;
        logic commit;
    } lkt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } lkt_stat_t;

endpackage

FILE: rtl/core/lkt_ifs.sv
// Handshake channel interfaces of the keyed entry table.
interface lkt_req_if #(parameter int KEY_WIDTH = 32) ();
    logic                       valid;
    logic                       ready;
    logic [lkt_pkg::FUNC_W-1:0] func;
    logic [KEY_WIDTH-1:0]       key;

    modport source (output valid, output func, output key, input ready);
    modport sink (input valid, input func, input key, output ready);
endinterface

interface lkt_rsp_if ();
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [lkt_pkg::SLOT_W-1:0] slot;
    logic                       evicted;
    logic [lkt_pkg::EKEY_W-1:0] evicted_key;

    modport source (output valid, output hit, output slot, output evicted,
                    output evicted_key, input ready);
    modport sink (input valid, input hit, input slot, input evicted,
                  input evicted_key, output ready);
endinterface

interface lkt_cfg_if ();
    logic                      valid;
    logic                      ready;
    logic [lkt_pkg::CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/lkt_ctrl.sv
// Sequencing state machine of the keyed entry table.
module lkt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  lkt_pkg::lkt_stat_t stat,
    output lkt_pkg::lkt_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        cmd.load    = 1'b0;
        cmd.scan_rd = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The last slot's compare completes in this cycle.
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/lkt_dp.sv
// Datapath of the keyed entry table: key store, slot scan, recency update, result register.
module lkt_dp #(
    parameter int ENTRIES   = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lkt_pkg::lkt_cmd_t          cmd,
    output lkt_pkg::lkt_stat_t         stat,
    input  logic                       cfg_we,
    input  logic [lkt_pkg::CAP_W-1:0]  cfg_data,
    input  logic [lkt_pkg::FUNC_W-1:0] req_func,
    input  logic [KEY_WIDTH-1:0]       req_key,
    input  logic                       rsp_ready,
    output logic                       rsp_valid,
    output logic                       rsp_hit,
    output logic [lkt_pkg::SLOT_W-1:0] rsp_slot,
    output logic                       rsp_evicted,
    output logic [lkt_pkg::EKEY_W-1:0] rsp_evicted_key
);

    localparam int IW    = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CW    = (CNT_W > lkt_pkg::CAP_W) ? CNT_W : lkt_pkg::CAP_W;

    // Key store: one write and one registered read per cycle.
    logic [KEY_WIDTH-1:0] key_mem [ENTRIES];

    logic [ENTRIES-1:0]         valid_reg, valid_next;
    logic [IW-1:0]              rank_reg [ENTRIES];
    logic [IW-1:0]              rank_next [ENTRIES];
    logic [CNT_W-1:0]           occ_reg, occ_next;
    logic [lkt_pkg::CAP_W-1:0]  cap_reg;

    logic [lkt_pkg::FUNC_W-1:0] func_reg;
    logic [KEY_WIDTH-1:0]       key_reg;
    logic [IW-1:0]              addr_reg;
    logic                       cmp_vld_reg;
    logic [IW-1:0]              cmp_idx_reg;
    logic [KEY_WIDTH-1:0]       rd_key_reg;

    logic                       found_reg, free_reg, old_reg;
    logic [IW-1:0]              found_idx_reg, free_idx_reg, old_idx_reg;
    logic [KEY_WIDTH-1:0]       old_key_reg;

    logic                       rsp_valid_reg;
    logic                       hit_reg, hit_next;
    logic [lkt_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic                       ev_reg, ev_next;
    logic [lkt_pkg::EKEY_W-1:0] ekey_reg, ekey_next;

    logic                       cmp_valid;
    logic [IW-1:0]              cmp_rank;
    logic [IW-1:0]              oldest_rank;
    logic [CNT_W-1:0]           occ_dec;
    logic [lkt_pkg::CAP_W-1:0]  eff_cap;
    logic                       full;
    logic                       found_set, free_set, old_set;

    logic                       do_age, age_all, set_tgt, mem_we;
    logic [IW-1:0]              age_limit, tgt_idx, slot_idx;
    logic [7:0]                 slot_wide;
    logic [63:0]                old_key_wide;

    // Slot compare stage, one slot per cycle.
    assign cmp_valid   = valid_reg[cmp_idx_reg];
    assign cmp_rank    = rank_reg[cmp_idx_reg];
    assign occ_dec     = occ_reg - CNT_W'(1);
    assign oldest_rank = occ_dec[IW-1:0];
    assign found_set   = cmp_vld_reg && cmp_valid && (rd_key_reg == key_reg) && !found_reg;
    assign free_set    = cmp_vld_reg && !cmp_valid && !free_reg;
    assign old_set     = cmp_vld_reg && cmp_valid && (cmp_rank == oldest_rank);

    // Capacity zero acts as one; above the table size it saturates.
    assign eff_cap = (cap_reg == '0) ? lkt_pkg::CAP_W'(1) : cap_reg;
    assign full    = (CW'(occ_reg) >= CW'(eff_cap)) || (occ_reg == CNT_W'(ENTRIES));

    assign stat.scan_last = (addr_reg == IW'(ENTRIES - 1));
    assign stat.out_busy  = rsp_valid_reg && !rsp_ready;

    assign old_key_wide = 64'(old_key_reg);
    assign slot_wide    = 8'(slot_idx);

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        hit_next   = 1'b0;
        ev_next    = 1'b0;
        ekey_next  = '0;
        slot_idx   = '0;
        do_age     = 1'b0;
        age_all    = 1'b0;
        age_limit  = '0;
        set_tgt    = 1'b0;
        tgt_idx    = '0;
        mem_we     = 1'b0;
        case (func_reg)
            lkt_pkg::FUNC_ACCESS:
            begin
                if (found_reg)
                begin
                    hit_next  = 1'b1;
                    slot_idx  = found_idx_reg;
                    do_age    = 1'b1;
                    age_limit = rank_reg[found_idx_reg];
                    set_tgt   = 1'b1;
                    tgt_idx   = found_idx_reg;
                end
                else if (full && old_reg)
                begin
                    // Reuse the least recent slot.
                    ev_next   = 1'b1;
                    ekey_next = old_key_wide[lkt_pkg::EKEY_W-1:0];
                    slot_idx  = old_idx_reg;
                    do_age    = 1'b1;
                    age_limit = oldest_rank;
                    set_tgt   = 1'b1;
                    tgt_idx   = old_idx_reg;
                    mem_we    = 1'b1;
                end
                else if (free_reg)
                begin
                    slot_idx = free_idx_reg;
                    do_age   = 1'b1;
                    age_all  = 1'b1;
                    set_tgt  = 1'b1;
                    tgt_idx  = free_idx_reg;
                    mem_we   = 1'b1;
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
            lkt_pkg::FUNC_PROBE:
            begin
                if (found_reg)
                begin
                    hit_next = 1'b1;
                    slot_idx = found_idx_reg;
                end
            end
            lkt_pkg::FUNC_CLEAR:
            begin
                valid_next = '0;
                occ_next   = '0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    rank_next[i] = '0;
                end
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (do_age && valid_reg[i] && (age_all || (rank_reg[i] < age_limit)))
            begin
                rank_next[i] = rank_reg[i] + IW'(1);
            end
        end
        if (set_tgt)
        begin
            rank_next[tgt_idx]  = '0;
            valid_next[tgt_idx] = 1'b1;
        end
        slot_next = slot_wide[lkt_pkg::SLOT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
        begin
            rd_key_reg <= key_mem[addr_reg];
        end
        if (cmd.commit && mem_we)
        begin
            key_mem[tgt_idx] <= key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            occ_reg       <= '0;
            cap_reg       <= lkt_pkg::CAP_RESET;
            addr_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            old_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            cmp_vld_reg <= cmd.scan_rd;
            if (cmd.load)
            begin
                addr_reg  <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
                old_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    addr_reg <= addr_reg + IW'(1);
                end
                if (found_set)
                begin
                    found_reg <= 1'b1;
                end
                if (free_set)
                begin
                    free_reg <= 1'b1;
                end
                if (old_set)
                begin
                    old_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                valid_reg     <= valid_next;
                rank_reg      <= rank_next;
                occ_reg       <= occ_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= req_func;
            key_reg  <= req_key;
        end
        cmp_idx_reg <= addr_reg;
        if (found_set)
        begin
            found_idx_reg <= cmp_idx_reg;
        end
        if (free_set)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (old_set)
        begin
            old_idx_reg <= cmp_idx_reg;
            old_key_reg <= rd_key_reg;
        end
        if (cmd.commit)
        begin
            hit_reg  <= hit_next;
            slot_reg <= slot_next;
            ev_reg   <= ev_next;
            ekey_reg <= ekey_next;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp_hit         = hit_reg;
    assign rsp_slot        = slot_reg;
    assign rsp_evicted     = ev_reg;
    assign rsp_evicted_key = ekey_reg;

endmodule

FILE: rtl/core/lru_keyed_entry_table_unit.sv
// Top level of the fully associative keyed entry table with least-recently-used replacement.
//
//  Channel | Role | Carries                                  | Transfer when
//  --------+------+------------------------------------------+---------------------------
//  req     | sink | func, key                                | req.valid && req.ready
//  rsp     | src  | hit, slot, evicted, evicted_key          | rsp.valid && rsp.ready
//  cfg     | sink | capacity (data)                          | cfg.valid && cfg.ready
//
// After a transfer, req.ready stays low while the item is worked on: the key store is
// read one slot per cycle across all ENTRIES slots, a drain state completes the last
// compare, and a commit state commits the recency update and loads the result register.
// The result register drives rsp, and rsp.valid rises when that register is loaded.
// Reset empties the table at once through per-slot valid bits and sets capacity to 16.
// A result still waiting on rsp does not block a new request; the following commit
// waits until the result register has been taken. cfg.ready is always high.
module lru_keyed_entry_table_unit #(
    parameter int ENTRIES   = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    lkt_req_if.sink   req,
    lkt_rsp_if.source rsp,
    lkt_cfg_if.sink   cfg
);

    lkt_pkg::lkt_cmd_t  cmd;
    lkt_pkg::lkt_stat_t stat;
    logic               req_ready;

    // The controller sequences the scan; the datapath owns all table state.
    lkt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lkt_dp #(
        .ENTRIES   (ENTRIES),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg.valid),
        .cfg_data        (cfg.data),
        .req_func        (req.func),
        .req_key         (req.key),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_hit         (rsp.hit),
        .rsp_slot        (rsp.slot),
        .rsp_evicted     (rsp.evicted),
        .rsp_evicted_key (rsp.evicted_key)
    );

    // Capacity writes are taken in any cycle.
    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;

endmodule

FILE: rtl/core/lkt_checker.sv
// Port-level checker of the keyed entry table and its bind to the top level.
module lkt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic                       rsp_hit,
    input logic [lkt_pkg::SLOT_W-1:0] rsp_slot,
    input logic                       rsp_evicted,
    input logic [lkt_pkg::EKEY_W-1:0] rsp_evicted_key
);

    // Only one request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while another is in progress");

    // A waiting result holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_slot) && $stable(rsp_hit)))
        else $error("result changed while stalled");

    // Eviction only happens on a miss.
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_evicted) |-> !rsp_hit)
        else $error("eviction reported with a hit");

    // Evicted key reads zero when nothing was removed.
    a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_evicted) |-> (rsp_evicted_key == '0))
        else $error("evicted key set without eviction");

endmodule

bind lru_keyed_entry_table_unit lkt_checker u_lkt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_hit         (rsp.hit),
    .rsp_slot        (rsp.slot),
    .rsp_evicted     (rsp.evicted),
    .rsp_evicted_key (rsp.evicted_key)
);
